// File: hw/rtl/anfs_pkg.sv
// ----------------------------------------------------------------------------
// anfs_pkg: shared types and constants
// Request structs and NAL codes for the Annex B start-code splitter.
// ----------------------------------------------------------------------------
package anfs_pkg;

  // start code pattern as seen in the three-byte history
  localparam logic [23:0] START_CODE   = 24'h000001;
  // history value after reset, never matches a start code
  localparam logic [23:0] HISTORY_INIT = 24'hffffff;
  // distance from the current byte back to the start code's first byte
  localparam int unsigned START_CODE_LEN = 3;
  localparam int unsigned OUT_WIDTH      = 32;

  // NAL unit types that close the open unit
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;

  // input request: one stream byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  // output request: one closed unit
  typedef struct packed {
    logic [OUT_WIDTH-1:0] frame_offset;
    logic [OUT_WIDTH-1:0] frame_length;
    logic [4:0]           next_unit_type;
  } out_t;

endpackage

// File: hw/rtl/anfs_core.sv
// ----------------------------------------------------------------------------
// anfs_core: start-code detection and unit tracking
// Holds history, position and open-unit state; flags a closed unit per byte.
// ----------------------------------------------------------------------------
module anfs_core #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  anfs_pkg::in_t item_i,
  output logic          hit_o,
  output anfs_pkg::out_t result_o
);
  import anfs_pkg::*;

  logic [23:0]               history_q, history_d;
  logic [POSITION_WIDTH-1:0] position_q, position_d;
  logic [POSITION_WIDTH-1:0] start_q, start_d;
  logic                      open_q, open_d;

  logic                      match;
  logic                      closes;
  logic [POSITION_WIDTH-1:0] boundary;
  logic [POSITION_WIDTH-1:0] length;
  logic [4:0]                nal_type;

  // start code seen in the three bytes before this one
  assign nal_type = item_i.data_byte[4:0];
  assign match    = (history_q == START_CODE) &&
                    (position_q >= POSITION_WIDTH'(START_CODE_LEN));
  assign boundary = position_q - POSITION_WIDTH'(START_CODE_LEN);
  assign closes   = nal_type inside {NAL_SLICE, NAL_IDR, NAL_SPS, NAL_PPS};
  assign length   = (boundary >= start_q) ? (boundary - start_q) : '0;
  assign hit_o    = step_i && match && open_q && closes;

  // result fields carry the low bits of the positions
  generate
    if (POSITION_WIDTH >= OUT_WIDTH) begin : g_trunc
      assign result_o.frame_offset = start_q[OUT_WIDTH-1:0];
      assign result_o.frame_length = length[OUT_WIDTH-1:0];
    end else begin : g_ext
      assign result_o.frame_offset = {{(OUT_WIDTH-POSITION_WIDTH){1'b0}}, start_q};
      assign result_o.frame_length = {{(OUT_WIDTH-POSITION_WIDTH){1'b0}}, length};
    end
  endgenerate
  assign result_o.next_unit_type = nal_type;

  // next state for one byte
  always_comb begin
    history_d  = history_q;
    position_d = position_q;
    start_d    = start_q;
    open_d     = open_q;
    if (step_i) begin
      if (match && !open_q) begin
        open_d  = 1'b1;
        start_d = boundary;
      end else if (match && closes) begin
        start_d = boundary;
      end
      history_d = {history_q[15:0], item_i.data_byte};
      // position saturates at the top of its range
      if (position_q != '1) begin
        position_d = position_q + POSITION_WIDTH'(1);
      end
      if (item_i.end_of_stream) begin
        history_d  = HISTORY_INIT;
        position_d = '0;
        start_d    = '0;
        open_d     = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q  <= HISTORY_INIT;
      position_q <= '0;
      start_q    <= '0;
      open_q     <= 1'b0;
    end else begin
      history_q  <= history_d;
      position_q <= position_d;
      start_q    <= start_d;
      open_q     <= open_d;
    end
  end

endmodule

// File: hw/rtl/annexb_nal_frame_splitter_top.sv
// ----------------------------------------------------------------------------
// annexb_nal_frame_splitter_top: Annex B NAL unit splitter
// Reports offset, length and closing type of each unit in a byte stream.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle, every cycle, as long as the result register
// is empty or being drained in the same cycle. Start-code detection, the
// position subtraction and the unit bookkeeping all settle within the cycle
// that takes the byte; a closed unit appears in the result register on the
// next cycle. A unit is closed by a start code whose NAL type is 1, 5, 7 or
// 8; other start codes stay inside the open unit, and the last unit of a
// stream is not reported. A byte marked end_of_stream is processed normally
// and then clears all state. Positions stop counting at their maximum value.
module annexb_nal_frame_splitter_top #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  anfs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output anfs_pkg::out_t out_data_o
);
  import anfs_pkg::*;

  logic accept;
  logic hit;
  out_t result;
  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  // take a byte when the result slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  anfs_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .item_i  (in_data_i),
    .hit_o   (hit),
    .result_o(result)
  );

  // result valid tracking
  always_comb begin
    if (accept) begin
      out_valid_d = hit;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for annexb_nal_frame_splitter_top
// Feeds Annex B byte streams (directed start-code cases, then random NAL
// units mixed with noise, broken start codes and end-of-stream marks) under
// random sender bursts and receiver stalls. A byte-level predictor tracks the
// start-code history and open unit and checks every reported unit in order.
// ----------------------------------------------------------------------------
module tb;
  import anfs_pkg::*;

  localparam int unsigned POS_W        = 32;
  localparam int          RANDOM_BYTES = 1350;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          IDLE_LIMIT   = 5000;

  // opening streams as {end_of_stream, data_byte}
  localparam int          N_OPENING = 28;
  localparam logic [8:0]  OPENING [N_OPENING] = '{
    // sps opens the first unit at position 0
    9'h000, 9'h000, 9'h001, 9'h067,
    // pps closes it
    9'h000, 9'h000, 9'h001, 9'h068,
    // sei is absorbed
    9'h000, 9'h000, 9'h001, 9'h006,
    // four-byte start code, idr with high header bits set
    9'h000, 9'h000, 9'h000, 9'h001, 9'h0e5,
    // overlapping start codes: type 0 absorbed, then a slice closes
    9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h001, 9'h041,
    // sps on the final byte still closes, then state clears
    9'h000, 9'h000, 9'h001, 9'h127
  };

  // tracks the open unit and holds the units still to be reported
  class nal_unit_scoreboard;
    logic [23:0]      hist;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] unit_start;
    logic             unit_open;
    out_t             pending_units[$];
    int               errors;

    function new();
      clear_stream();
      errors = 0;
    endfunction

    function void clear_stream();
      hist       = HISTORY_INIT;
      pos        = '0;
      unit_start = '0;
      unit_open  = 1'b0;
    endfunction

    // advance the predictor by one accepted byte
    function void note_byte(in_t req);
      logic [4:0]       nal_type;
      logic [POS_W-1:0] boundary;
      out_t             unit;
      nal_type = req.data_byte[4:0];
      if (hist == START_CODE && pos >= START_CODE_LEN) begin
        boundary = pos - START_CODE_LEN;
        if (!unit_open) begin
          unit_open  = 1'b1;
          unit_start = boundary;
        end else if (nal_type == NAL_SLICE || nal_type == NAL_IDR ||
                     nal_type == NAL_SPS || nal_type == NAL_PPS) begin
          unit.frame_offset   = unit_start;
          unit.frame_length   = (boundary >= unit_start) ? boundary - unit_start : '0;
          unit.next_unit_type = nal_type;
          pending_units.push_back(unit);
          unit_start = boundary;
        end
      end
      hist = {hist[15:0], req.data_byte};
      if (pos != '1) pos++;
      if (req.end_of_stream) clear_stream();
    endfunction

    // compare one reported unit with the oldest expected one
    function void check_unit(out_t got);
      out_t exp_unit;
      if (pending_units.size() == 0) begin
        $error("unexpected unit: offset %0d length %0d type %0d",
               got.frame_offset, got.frame_length, got.next_unit_type);
        errors++;
        return;
      end
      exp_unit = pending_units.pop_front();
      if (got.frame_offset !== exp_unit.frame_offset) begin
        $error("frame_offset: expected %0d, got %0d",
               exp_unit.frame_offset, got.frame_offset);
        errors++;
      end
      if (got.frame_length !== exp_unit.frame_length) begin
        $error("frame_length: expected %0d, got %0d",
               exp_unit.frame_length, got.frame_length);
        errors++;
      end
      if (got.next_unit_type !== exp_unit.next_unit_type) begin
        $error("next_unit_type: expected %0d, got %0d",
               exp_unit.next_unit_type, got.next_unit_type);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  nal_unit_scoreboard sb;
  int bytes_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit hold_done   = 1'b0;

  annexb_nal_frame_splitter_top #(
    .POSITION_WIDTH(POS_W)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // send one byte request, opening a new burst after a random gap when due
  task automatic send_byte(input logic [7:0] data, input logic eos);
    in_t req;
    int  gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    req.data_byte     = data;
    req.end_of_stream = eos;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(req);
    bytes_sent++;
    burst_left--;
  endtask

  // random payload byte, zero-heavy so start-code fragments show up
  function automatic logic [7:0] payload_byte();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  // stimulus
  initial begin
    int         kind;
    int         n;
    logic [4:0] nal_type;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) send_byte(OPENING[i][7:0], OPENING[i][8]);

    while (bytes_sent < N_OPENING + RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 63) == 0);
      end else if (kind == 1) begin
        // broken start codes
        case ($urandom_range(0, 2))
          0: begin
            send_byte(8'h00, 1'b0);
            send_byte(8'h01, 1'b0);
          end
          1: begin
            send_byte(8'h00, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(8'($urandom_range(2, 255)), 1'b0);
          end
          default: begin
            send_byte(8'h01, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(8'h00, 1'b0);
          end
        endcase
      end else begin
        // well-formed unit: start code, header, payload
        if ($urandom_range(0, 3) == 0) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, $urandom_range(0, 99) == 0);
        case ($urandom_range(0, 5))
          0: nal_type = NAL_SLICE;
          1: nal_type = NAL_IDR;
          2: nal_type = NAL_SPS;
          3: nal_type = NAL_PPS;
          default: nal_type = 5'($urandom_range(0, 31));
        endcase
        n = $urandom_range(0, 12);
        send_byte({3'($urandom_range(0, 7)), nal_type},
                  (n == 0) && ($urandom_range(0, 15) == 0));
        for (int i = 0; i < n; i++) begin
          send_byte(payload_byte(), (i == n - 1) && ($urandom_range(0, 15) == 0));
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_units.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off to back up the input
  initial begin
    int mode;
    int len;
    @(posedge rst_n);
    forever begin
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 60);
        repeat (len) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_unit(out_data);
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule
